// ===== src/assert_macros.svh =====
// shared assertion macros for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds in this cycle, consequent in the same cycle
`define ARVC_ASSERT_SAME(lbl, clk_s, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent holds in this cycle, consequent in the next cycle
`define ARVC_ASSERT_NEXT(lbl, clk_s, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/arvc_pkg.sv =====
`default_nettype none

package arvc_pkg;

	localparam int NUM_W = 62;
	localparam int ERR_W = 3;

	// request kinds carried on tuser
	localparam logic REQ_HEADER = 1'b0;
	localparam logic REQ_RANGE  = 1'b1;

	// status codes
	localparam logic [ERR_W-1:0] ST_OK        = 3'd0;
	localparam logic [ERR_W-1:0] ST_FIRST_BIG = 3'd1;
	localparam logic [ERR_W-1:0] ST_ZERO_LEN  = 3'd2;
	localparam logic [ERR_W-1:0] ST_GAP_UNDER = 3'd3;
	localparam logic [ERR_W-1:0] ST_LEN_UNDER = 3'd4;

	// stream widths, five numbers packed and padded to bytes
	localparam int IN_FIELDS_W = 5 * NUM_W;
	localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_DATA_W  = 8;

	typedef struct packed {
		logic             frame_open;
		logic [NUM_W-1:0] cur_smallest;
		logic [ERR_W-1:0] err_code;
		logic [NUM_W-1:0] query_hold;
		logic             cover_found;
		logic             cover_decided;
		logic             chain_ended;
	} arvc_state_t;

endpackage

`default_nettype wire

// ===== src/arvc_step.sv =====
`default_nettype none

module arvc_step (
	input  arvc_pkg::arvc_state_t           state_q,
	input  logic                            req_type,
	input  logic [arvc_pkg::NUM_W-1:0]      top_acked,
	input  logic [arvc_pkg::NUM_W-1:0]      first_range_len,
	input  logic [arvc_pkg::NUM_W-1:0]      query_number,
	input  logic [arvc_pkg::NUM_W-1:0]      gap_value,
	input  logic [arvc_pkg::NUM_W-1:0]      range_len,
	input  logic                            is_last,
	output arvc_pkg::arvc_state_t           state_d,
	output logic                            emit,
	output logic [arvc_pkg::ERR_W-1:0]      status_code,
	output logic                            covered
);
	import arvc_pkg::*;

	logic             hdr_first_big;
	logic [NUM_W-1:0] hdr_small;
	logic [NUM_W:0]   gap_plus2;
	logic             gap_under;
	logic [NUM_W-1:0] rng_hi;
	logic [NUM_W-1:0] len_m1;
	logic             len_zero;
	logic             len_under;
	logic [NUM_W-1:0] rng_lo;
	logic             q_above_hi;
	logic             q_at_least_lo;
	arvc_state_t      nxt;
	logic             emit_v;

	// header checks
	assign hdr_first_big = first_range_len > top_acked;
	assign hdr_small     = top_acked - first_range_len;

	// range checks, gap plus two kept one bit wider so it cannot wrap
	assign gap_plus2     = {1'b0, gap_value} + (NUM_W+1)'(2);
	assign gap_under     = {1'b0, state_q.cur_smallest} < gap_plus2;
	assign rng_hi        = state_q.cur_smallest - gap_value - NUM_W'(2);
	assign len_zero      = range_len == '0;
	assign len_m1        = range_len - NUM_W'(1);
	assign len_under     = len_m1 > rng_hi;
	assign rng_lo        = rng_hi - len_m1;
	assign q_above_hi    = state_q.query_hold > rng_hi;
	assign q_at_least_lo = state_q.query_hold >= rng_lo;

	always_comb begin
		nxt    = state_q;
		emit_v = 1'b0;
		if (req_type == REQ_HEADER) begin
			nxt.frame_open    = 1'b1;
			nxt.err_code      = ST_OK;
			nxt.query_hold    = query_number;
			nxt.cover_found   = 1'b0;
			nxt.cover_decided = 1'b0;
			nxt.chain_ended   = 1'b0;
			nxt.cur_smallest  = '0;
			if (hdr_first_big) begin
				nxt.err_code = ST_FIRST_BIG;
			end else begin
				nxt.cur_smallest = hdr_small;
				if (query_number > top_acked) begin
					nxt.cover_decided = 1'b1;
				end else if (query_number >= hdr_small) begin
					nxt.cover_decided = 1'b1;
					nxt.cover_found   = 1'b1;
				end
			end
			emit_v = is_last;
		end else if (state_q.frame_open) begin
			emit_v = is_last;
			if (state_q.err_code == ST_OK && !state_q.chain_ended) begin
				if (len_zero) begin
					nxt.err_code = ST_ZERO_LEN;
				end else if (gap_under) begin
					nxt.err_code = ST_GAP_UNDER;
				end else if (len_under) begin
					nxt.err_code = ST_LEN_UNDER;
				end else begin
					nxt.cur_smallest = rng_lo;
					if (!state_q.cover_decided) begin
						if (q_above_hi) begin
							nxt.cover_decided = 1'b1;
							nxt.cover_found   = 1'b0;
						end else if (q_at_least_lo) begin
							nxt.cover_decided = 1'b1;
							nxt.cover_found   = 1'b1;
						end
					end
					// chain reached zero, nothing below is left to cover
					if (rng_lo == '0) begin
						nxt.chain_ended = 1'b1;
						if (!nxt.cover_decided) begin
							nxt.cover_decided = 1'b1;
							nxt.cover_found   = 1'b0;
						end
					end
				end
			end
		end
		if (emit_v) begin
			nxt.frame_open = 1'b0;
		end
	end

	assign state_d     = nxt;
	assign emit        = emit_v;
	assign status_code = nxt.err_code;
	assign covered     = (nxt.err_code == ST_OK) && nxt.cover_decided && nxt.cover_found;

endmodule

`default_nettype wire

// ===== src/ack_range_validate_and_cover.sv =====
// ack range validate and cover: walks the range chain of one acknowledgement
// frame. a header request (tuser 0) opens the frame with the largest acked
// number, the first range length and a packet number under test; each range
// request (tuser 1) brings an already decoded gap and length. the frame is
// checked for a first range larger than the largest number, zero lengths,
// gap underflow and length underflow (first error wins), and the block finds
// whether the test number sits inside any range. one result leaves after the
// request marked with tlast: tdata holds the status code and the covered
// flag, which is 0 whenever the status is not ok. range requests with no
// open frame are dropped, and a header while a frame is open abandons the
// old frame without a result. rate: one request per clock, unless a
// request that makes a result waits for the result slot. the last request
// of a frame passes through the input register and the step logic into the
// result register. the range walk state is updated by the step logic
// between the input register and the result register. while a result waits
// on m_axis_tready the input register still takes requests; a request that
// makes a result then waits there until the result slot frees, and stalls s_axis_tready.
`default_nettype none

module ack_range_validate_and_cover (
	input  logic                                clk,
	input  logic                                arst_n,
	// request stream
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// [61:0] top_acked, [123:62] first_range_len, [185:124] query_number,
	// [247:186] gap_value, [309:248] range_len, [311:310] zero
	input  logic [arvc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// [0] req_type
	input  logic                                s_axis_tuser,
	// is_last
	input  logic                                s_axis_tlast,
	// result stream
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [2:0] status_code, [3] covered, [7:4] zero
	output logic [arvc_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
	import arvc_pkg::*;

	// input register
	logic             item_valid_s1;
	logic             req_type_s1;
	logic             is_last_s1;
	logic [NUM_W-1:0] top_acked_s1;
	logic [NUM_W-1:0] first_range_len_s1;
	logic [NUM_W-1:0] query_number_s1;
	logic [NUM_W-1:0] gap_value_s1;
	logic [NUM_W-1:0] range_len_s1;

	// frame walk state
	arvc_state_t      state_q;
	arvc_state_t      state_d;

	// result register
	logic             out_valid_q;
	logic [ERR_W-1:0] out_status_q;
	logic             out_covered_q;

	logic             emit;
	logic [ERR_W-1:0] step_status;
	logic             step_covered;
	logic             out_free;
	logic             advance;
	logic             in_accept;

	arvc_step u_step (
		.state_q         (state_q),
		.req_type        (req_type_s1),
		.top_acked       (top_acked_s1),
		.first_range_len (first_range_len_s1),
		.query_number    (query_number_s1),
		.gap_value       (gap_value_s1),
		.range_len       (range_len_s1),
		.is_last         (is_last_s1),
		.state_d         (state_d),
		.emit            (emit),
		.status_code     (step_status),
		.covered         (step_covered)
	);

	// result slot is free when empty or being taken this cycle
	assign out_free      = !out_valid_q || m_axis_tready;
	// a request that makes no result never waits on the output side
	assign advance       = item_valid_s1 && (!emit || out_free);
	assign s_axis_tready = !item_valid_s1 || advance;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (in_accept) begin
			item_valid_s1 <= 1'b1;
		end else if (advance) begin
			item_valid_s1 <= 1'b0;
		end
	end

	// request payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_accept) begin
			req_type_s1        <= s_axis_tuser;
			is_last_s1         <= s_axis_tlast;
			top_acked_s1       <= s_axis_tdata[NUM_W-1:0];
			first_range_len_s1 <= s_axis_tdata[2*NUM_W-1:NUM_W];
			query_number_s1    <= s_axis_tdata[3*NUM_W-1:2*NUM_W];
			gap_value_s1       <= s_axis_tdata[4*NUM_W-1:3*NUM_W];
			range_len_s1       <= s_axis_tdata[5*NUM_W-1:4*NUM_W];
		end
	end

	// walk state moves once per request taken from the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_status_q  <= step_status;
			out_covered_q <= step_covered;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_DATA_W-ERR_W-1){1'b0}}, out_covered_q, out_status_q};

endmodule

`default_nettype wire

// ===== src/arvc_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module arvc_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	input  logic                                s_axis_tready,
	input  logic [arvc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	input  logic                                s_axis_tuser,
	input  logic                                s_axis_tlast,
	input  logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	input  logic [arvc_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
	import arvc_pkg::*;

	// a stalled result keeps its contents
	`ARVC_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

	// covered only goes with an ok status
	`ARVC_ASSERT_SAME(a_cover_ok, clk, arst_n, m_axis_tvalid && m_axis_tdata[ERR_W], m_axis_tdata[ERR_W-1:0] == ST_OK, "covered set on a failed frame")

	// status is one of the defined codes
	`ARVC_ASSERT_SAME(a_status_range, clk, arst_n, m_axis_tvalid, m_axis_tdata[ERR_W-1:0] <= ST_LEN_UNDER, "status code out of range")

	// a result appears only after a request was taken
	`ARVC_ASSERT_SAME(a_no_spurious, clk, arst_n, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready, 2) || $past(!s_axis_tready), "result with no request behind it")

endmodule

bind ack_range_validate_and_cover arvc_checker u_arvc_checker (.*);

`default_nettype wire

// ===== tb/sv/ack_frame_checker.sv =====
`default_nettype none

module ack_frame_checker
	import arvc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	// [61:0] top_acked, [123:62] first_range_len, [185:124] query_number,
	// [247:186] gap_value, [309:248] range_len, [311:310] zero
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// [0] req_type
	input  logic                  s_axis_tuser,
	input  logic                  s_axis_tlast,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [2:0] status_code, [3] covered, [7:4] zero
	input  logic [OUT_DATA_W-1:0] m_axis_tdata,
	output int                    mismatches,
	output int                    verdicts_owed
);

	typedef struct packed {
		logic [ERR_W-1:0] status;
		logic             covered;
	} ack_verdict_t;

	ack_verdict_t verdicts_due[$];

	// shadow of the range walk
	logic             frame_live;
	logic [63:0]      walk_smallest;
	logic [ERR_W-1:0] first_err;
	logic [63:0]      probe_num;
	logic             probe_hit;
	logic             probe_known;
	logic             walk_done;

	task automatic report_mismatch(input string what, input int got_v, input int want_v);
		$display("mismatch at %0t: %s, got %0d, want %0d", $time, what, got_v, want_v);
		mismatches++;
	endtask

	// coverage of the probe is settled by the first range that reaches it
	task automatic settle_cover(input logic [63:0] hi, input logic [63:0] lo);
		if (!probe_known) begin
			if (probe_num > hi) begin
				probe_known = 1'b1;
				probe_hit   = 1'b0;
			end else if (probe_num >= lo) begin
				probe_known = 1'b1;
				probe_hit   = 1'b1;
			end
		end
	endtask

	task automatic walk_range(input logic [63:0] gap, input logic [63:0] len);
		logic [63:0] hi;
		hi = 64'd0;
		if (first_err == ST_OK && !walk_done) begin
			if (len == 64'd0) begin
				first_err = ST_ZERO_LEN;
			end else if (walk_smallest < gap + 64'd2) begin
				first_err = ST_GAP_UNDER;
			end else begin
				hi = walk_smallest - gap - 64'd2;
				if (len - 64'd1 > hi) begin
					first_err = ST_LEN_UNDER;
				end else begin
					walk_smallest = hi - (len - 64'd1);
					settle_cover(hi, walk_smallest);
					if (walk_smallest == 64'd0) begin
						walk_done = 1'b1;
						if (!probe_known) begin
							probe_known = 1'b1;
							probe_hit   = 1'b0;
						end
					end
				end
			end
		end
	endtask

	task automatic absorb_request(input logic kind, input logic [IN_DATA_W-1:0] data,
		input logic last);
		logic [63:0] largest;
		logic [63:0] first;
		ack_verdict_t v;
		largest = {2'b00, data[0 +: NUM_W]};
		first   = {2'b00, data[NUM_W +: NUM_W]};
		if (kind == REQ_HEADER) begin
			frame_live    = 1'b1;
			first_err     = ST_OK;
			probe_num     = {2'b00, data[2*NUM_W +: NUM_W]};
			probe_hit     = 1'b0;
			probe_known   = 1'b0;
			walk_done     = 1'b0;
			walk_smallest = 64'd0;
			if (first > largest) begin
				first_err = ST_FIRST_BIG;
			end else begin
				walk_smallest = largest - first;
				settle_cover(largest, walk_smallest);
			end
		end else if (frame_live) begin
			walk_range({2'b00, data[3*NUM_W +: NUM_W]}, {2'b00, data[4*NUM_W +: NUM_W]});
		end
		// orphan ranges never produce a verdict, even with tlast
		if (last && (kind == REQ_HEADER || frame_live)) begin
			v.status  = first_err;
			v.covered = (first_err == ST_OK) && probe_known && probe_hit;
			verdicts_due.push_back(v);
			frame_live = 1'b0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		ack_verdict_t want;
		if (!arst_n) begin
			frame_live    = 1'b0;
			walk_smallest = 64'd0;
			first_err     = ST_OK;
			probe_num     = 64'd0;
			probe_hit     = 1'b0;
			probe_known   = 1'b0;
			walk_done     = 1'b0;
			verdicts_due.delete();
			mismatches    = 0;
			verdicts_owed = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (verdicts_due.size() == 0) begin
					report_mismatch("result with nothing owed", int'(m_axis_tdata), -1);
				end else begin
					want = verdicts_due.pop_front();
					if (m_axis_tdata[ERR_W-1:0] !== want.status)
						report_mismatch("status_code", int'(m_axis_tdata[ERR_W-1:0]),
							int'(want.status));
					if (m_axis_tdata[ERR_W] !== want.covered)
						report_mismatch("covered", int'(m_axis_tdata[ERR_W]),
							int'(want.covered));
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				absorb_request(s_axis_tuser, s_axis_tdata, s_axis_tlast);
			verdicts_owed = verdicts_due.size();
		end
	end

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`default_nettype none

module tb;
	import arvc_pkg::*;

	localparam logic [63:0] NUM_MAX = 64'h3FFF_FFFF_FFFF_FFFF;
	// random part, split evenly over the idling phases
	localparam int PHASE_ITEMS = 325;
	// receiver hold-off long enough to back the block up into its input
	localparam int HOLD_OFF_CYCLES = 300;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
	logic                  s_axis_tuser  = 1'b0;
	logic                  s_axis_tlast  = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	int mismatches;
	int verdicts_owed;

	// idling knobs, percent of cycles
	int idle_pct  = 0;
	int stall_pct = 0;
	int idle_by_phase[4]  = '{0, 73, 0, 38};
	int stall_by_phase[4] = '{0, 0, 73, 38};

	// hold-off handoff from the stimulus to the receiver process
	int hold_req  = 0;
	int hold_left = 0;

	// generator side view: a frame has been opened and not yet closed by tlast
	bit gen_open = 1'b0;

	ack_range_validate_and_cover i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	ack_frame_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.mismatches    (mismatches),
		.verdicts_owed (verdicts_owed)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// receiver: random stalls, or a counted hold-off when one is asked for
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (hold_left > 0) begin
				m_axis_tready = 1'b0;
				hold_left--;
			end else begin
				m_axis_tready = ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// full width 62-bit random number, top two bits clear
	function automatic logic [63:0] rand62();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r & NUM_MAX;
	endfunction

	function automatic logic [63:0] rand_upto(input logic [63:0] n);
		logic [63:0] r;
		r = {$urandom, $urandom};
		if (n == 64'd0)
			return 64'd0;
		return r % (n + 64'd1);
	endfunction

	// leans toward the bound and toward small values so chains end and touch edges
	function automatic logic [63:0] lean_upto(input logic [63:0] n);
		case ($urandom_range(3))
			0: return n;
			1: return rand_upto((n < 64'd8) ? n : 64'd8);
			default: return rand_upto(n);
		endcase
	endfunction

	// one request on the input stream; called and returns at a falling edge.
	// tvalid stays high into the next request unless an idle cycle is drawn
	task automatic offer(input logic kind, input logic [63:0] largest, input logic [63:0] first,
		input logic [63:0] query, input logic [63:0] gap, input logic [63:0] len,
		input logic last);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = {2'b00, len[NUM_W-1:0], gap[NUM_W-1:0], query[NUM_W-1:0],
			first[NUM_W-1:0], largest[NUM_W-1:0]};
		s_axis_tuser  = kind;
		s_axis_tlast  = last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
		if (kind == REQ_HEADER)
			gen_open = !last;
		else if (last)
			gen_open = 1'b0;
	endtask

	// one frame: mostly a well formed chain with random content, sometimes
	// an injected error, an orphan range ahead of it, or abandoned halfway
	task automatic send_frame(inout int count);
		logic [63:0] largest;
		logic [63:0] first;
		logic [63:0] query;
		logic [63:0] smallest;
		logic [63:0] hi;
		logic [63:0] gap;
		logic [63:0] len;
		int n_ranges;
		bit abandon;
		bit last;

		if (!gen_open && $urandom_range(99) < 4)
			offer(REQ_RANGE, rand62(), rand62(), rand62(), rand62(), rand62(),
				1'($urandom_range(1)));

		case ($urandom_range(3))
			0: largest = 64'($urandom_range(40));
			1: largest = 64'($urandom_range(2000));
			2: largest = rand62();
			default: largest = NUM_MAX - 64'($urandom_range(50));
		endcase

		if ($urandom_range(99) < 5 && largest != NUM_MAX)
			first = largest + 64'd1 + rand_upto((NUM_MAX - largest - 64'd1 < 64'd4) ?
				NUM_MAX - largest - 64'd1 : 64'd4);
		else if ($urandom_range(99) < 12)
			first = largest;
		else
			first = lean_upto(($urandom_range(1) == 0 && largest > 64'd20) ? 64'd20 : largest);

		case ($urandom_range(3))
			0: query = rand_upto(largest);
			1: query = largest - rand_upto((largest < 64'd30) ? largest : 64'd30);
			2: query = rand62();
			default: query = rand_upto((largest < 64'd30) ? largest : 64'd30);
		endcase

		n_ranges = ($urandom_range(7) == 0) ? $urandom_range(12) : $urandom_range(5);
		abandon  = ($urandom_range(99) < 5);

		// header carries garbage in the range fields, the block must ignore it
		offer(REQ_HEADER, largest, first, query, rand62(), rand62(), n_ranges == 0 && !abandon);
		count++;
		smallest = (first > largest) ? 64'd0 : largest - first;

		for (int i = 0; i < n_ranges; i++) begin
			last = (i == n_ranges - 1) && !abandon;
			if ($urandom_range(99) < 5) begin
				case ($urandom_range(2))
					0: begin
						gap = rand62();
						len = 64'd0;
					end
					1: begin
						// gap just big enough to run under the smallest number
						gap = ((smallest >= 64'd1) ? smallest - 64'd1 : 64'd0) + rand_upto(3);
						gap = gap & NUM_MAX;
						len = 64'd1 + lean_upto(3);
					end
					default: begin
						gap = (smallest >= 64'd2) ? lean_upto(smallest - 64'd2) : rand_upto(3);
						hi  = (smallest >= gap + 64'd2) ? smallest - gap - 64'd2 : 64'd0;
						len = (hi + 64'd2 + rand_upto(5)) & NUM_MAX;
					end
				endcase
			end else if (smallest >= 64'd2) begin
				gap      = lean_upto(smallest - 64'd2);
				hi       = smallest - gap - 64'd2;
				len      = 64'd1 + lean_upto(hi);
				smallest = hi - (len - 64'd1);
			end else begin
				// chain already at the bottom: ignored or a gap underflow
				gap = lean_upto(3);
				len = 64'd1 + lean_upto(3);
			end
			offer(REQ_RANGE, rand62(), rand62(), rand62(), gap, len, last);
			count++;
		end
	endtask

	initial begin
		int phase_items;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part, no idling on either side
		// range request with no open frame, marked last: dropped
		offer(REQ_RANGE, 0, 0, 0, 5, 3, 1'b1);
		// whole space acked in the first range, probe at zero
		offer(REQ_HEADER, NUM_MAX, NUM_MAX, 0, 0, 0, 1'b1);
		// first range bigger than the largest number
		offer(REQ_HEADER, 0, 1, 0, 0, 0, 1'b1);
		// probe at the very top
		offer(REQ_HEADER, NUM_MAX, 0, NUM_MAX, 0, 0, 1'b1);
		// zero length range
		offer(REQ_HEADER, 100, 10, 50, 0, 0, 1'b0);
		offer(REQ_RANGE, 0, 0, 0, 0, 0, 1'b1);
		// first range alone reaches zero, next range is a gap underflow
		offer(REQ_HEADER, 10, 10, 5, 0, 0, 1'b0);
		offer(REQ_RANGE, 0, 0, 0, 0, 1, 1'b1);
		// length underflow
		offer(REQ_HEADER, 100, 0, 50, 0, 0, 1'b0);
		offer(REQ_RANGE, 0, 0, 0, 97, 5, 1'b1);
		// chain reaches zero, later broken range is ignored, probe in a hole
		offer(REQ_HEADER, 20, 2, 12, 0, 0, 1'b0);
		offer(REQ_RANGE, 0, 0, 0, 0, 4, 1'b0);
		offer(REQ_RANGE, 0, 0, 0, 0, 12, 1'b0);
		offer(REQ_RANGE, 0, 0, 0, NUM_MAX, 0, 1'b1);
		// header over an open frame abandons it
		offer(REQ_HEADER, 50, 0, 50, 0, 0, 1'b0);
		offer(REQ_HEADER, 30, 5, 27, 0, 0, 1'b1);
		// probe below every range, coverage never decided
		offer(REQ_HEADER, 30, 0, 5, 0, 0, 1'b0);
		offer(REQ_RANGE, 0, 0, 0, 0, 3, 1'b1);
		// first error wins over a later gap underflow
		offer(REQ_HEADER, 100, 0, 7, 0, 0, 1'b0);
		offer(REQ_RANGE, 0, 0, 0, 4, 0, 1'b0);
		offer(REQ_RANGE, 0, 0, 0, NUM_MAX, 1, 1'b1);
		// probe found in a range after a gap
		offer(REQ_HEADER, 100, 9, 80, 0, 0, 1'b0);
		offer(REQ_RANGE, 0, 0, 0, 3, 10, 1'b1);
		// largest gap and length at the top of the space
		offer(REQ_HEADER, NUM_MAX, 0, 0, 0, 0, 1'b0);
		offer(REQ_RANGE, 0, 0, 0, NUM_MAX, NUM_MAX, 1'b1);

		// random part over the idling phases; the first phase also holds the
		// receiver off long enough for the block to stall its input
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct    = idle_by_phase[ph];
			stall_pct   = stall_by_phase[ph];
			phase_items = 0;
			if (ph == 0)
				hold_req = HOLD_OFF_CYCLES;
			while (phase_items < PHASE_ITEMS)
				send_frame(phase_items);
		end

		s_axis_tvalid = 1'b0;
		s_axis_tlast  = 1'b0;
		while (verdicts_owed != 0)
			@(negedge clk);
		// run on to catch results nobody asked for
		repeat (20) @(negedge clk);

		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// the slowest correct run is well under a tenth of this
	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire
